@@ rtl/srm_pkg.sv @@
// shared widths, limits and types for the rms meter
package srm_pkg;

    localparam int MAX_SAMPLES  = 4096;
    localparam int SAMPLE_W     = 16;
    localparam int RMS_W        = 16;
    localparam int COUNT_OUT_W  = 13;
    localparam int SQ_W         = 2 * SAMPLE_W - 1;
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W        = SQ_W + CNT_W;
    localparam int RAD_W        = 2 * RMS_W;
    localparam int DIV_STEP_W   = $clog2(SUM_W);
    localparam int SQRT_STEP_W  = $clog2(RMS_W);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } job_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              empty;
    } queue_status_t;

endpackage

@@ rtl/srm_if.sv @@
// stream interfaces for samples in and results out
interface srm_in_if
    import srm_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface srm_out_if
    import srm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [RMS_W-1:0]       rms;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   overflow;

    modport source (output valid, output rms, output sample_count, output overflow,
                    input ready);
    modport sink   (input valid, input rms, input sample_count, input overflow,
                    output ready);
endinterface

@@ rtl/srm_front.sv @@
// sample squaring and block accumulation, hands closed blocks to the queue
module srm_front
    import srm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    srm_in_if.sink        samples,
    input  queue_status_t q_status,
    output logic          push,
    output job_t          push_job
);

    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic [SQ_W-1:0]      s1_sq_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 can_add;
    logic signed [2*SAMPLE_W-1:0] product;
    logic [QLVL_W:0]      reserved;
    logic                 in_xfer;

    // a closing sample in flight already holds a queue slot
    assign reserved      = {1'b0, q_status.level} + (QLVL_W + 1)'(s1_valid_reg & s1_last_reg);
    assign samples.ready = (reserved < (QLVL_W + 1)'(QUEUE_DEPTH));
    assign in_xfer       = samples.valid & samples.ready;
    assign product       = samples.sample * samples.sample;

    always_comb
    begin
        can_add    = (count_reg < CNT_W'(MAX_SAMPLES));
        sum_next   = can_add ? (sum_reg + SUM_W'(s1_sq_reg)) : sum_reg;
        count_next = can_add ? (count_reg + CNT_W'(1)) : count_reg;
        ovf_next   = ovf_reg | ~can_add;
    end

    assign push              = s1_valid_reg & s1_last_reg;
    assign push_job.sum      = sum_next;
    assign push_job.count    = count_next;
    assign push_job.overflow = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
            if (in_xfer)
            begin
                s1_last_reg <= samples.is_last;
                s1_sq_reg   <= product[SQ_W-1:0];
            end
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

endmodule

@@ rtl/srm_queue.sv @@
// short queue of closed blocks between accumulation and the divide/root engine
module srm_queue
    import srm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head,
    output queue_status_t status
);

    job_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign head         = entries[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.empty = (level_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + QLVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - QLVL_W'(1);
            end
        end
    end

endmodule

@@ rtl/srm_back.sv @@
// restoring divide for the mean, digit-by-digit square root, result register
module srm_back
    import srm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  job_t          head,
    output logic          pop,
    srm_out_if.source     results
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_HOLD} state_t;

    state_t                 state_reg;
    logic [SUM_W-1:0]       quo_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       divisor_reg;
    logic                   ovf_reg;
    logic [DIV_STEP_W-1:0]  div_step_reg;
    logic [RAD_W-1:0]       rad_reg;
    logic [RMS_W-1:0]       root_reg;
    logic [RMS_W+1:0]       srem_reg;
    logic [SQRT_STEP_W-1:0] sqrt_step_reg;

    logic                   out_valid_reg;
    logic [RMS_W-1:0]       out_rms_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_ovf_reg;

    logic [CNT_W:0]         rem_sh;
    logic                   div_ge;
    logic [CNT_W:0]         rem_diff;
    logic [CNT_W-1:0]       rem_next;
    logic [SUM_W-1:0]       quo_next;
    logic [RMS_W+3:0]       srem_sh;
    logic [RMS_W+3:0]       trial;
    logic                   sqrt_ge;
    logic [RMS_W+3:0]       srem_diff;
    logic [RMS_W+1:0]       srem_next;
    logic [RMS_W-1:0]       root_next;
    logic                   out_free;

    assign pop      = (state_reg == ST_IDLE) & ~q_status.empty;
    assign out_free = ~out_valid_reg | results.ready;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        div_ge   = (rem_sh >= {1'b0, divisor_reg});
        rem_diff = rem_sh - {1'b0, divisor_reg};
        rem_next = div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], div_ge};

        srem_sh   = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        sqrt_ge   = (srem_sh >= trial);
        srem_diff = srem_sh - trial;
        srem_next = sqrt_ge ? srem_diff[RMS_W+1:0] : srem_sh[RMS_W+1:0];
        root_next = {root_reg[RMS_W-2:0], sqrt_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_step_reg  <= '0;
            sqrt_step_reg <= '0;
        end
        else
        begin
            if ((state_reg == ST_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        quo_reg      <= head.sum;
                        rem_reg      <= '0;
                        divisor_reg  <= head.count;
                        ovf_reg      <= head.overflow;
                        div_step_reg <= '0;
                        state_reg    <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    quo_reg      <= quo_next;
                    rem_reg      <= rem_next;
                    div_step_reg <= div_step_reg + DIV_STEP_W'(1);
                    if (div_step_reg == DIV_STEP_W'(SUM_W - 1))
                    begin
                        // empty block gives zero
                        rad_reg       <= (divisor_reg == '0) ? '0 : quo_next[RAD_W-1:0];
                        root_reg      <= '0;
                        srem_reg      <= '0;
                        sqrt_step_reg <= '0;
                        state_reg     <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    rad_reg       <= {rad_reg[RAD_W-3:0], 2'b00};
                    root_reg      <= root_next;
                    srem_reg      <= srem_next;
                    sqrt_step_reg <= sqrt_step_reg + SQRT_STEP_W'(1);
                    if (sqrt_step_reg == SQRT_STEP_W'(RMS_W - 1))
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_rms_reg   <= root_reg;
                        out_count_reg <= COUNT_OUT_W'(divisor_reg);
                        out_ovf_reg   <= ovf_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.rms          = out_rms_reg;
    assign results.sample_count = out_count_reg;
    assign results.overflow     = out_ovf_reg;

endmodule

@@ rtl/signal_rms_meter.sv @@
// top level of the block rms meter
//
// samples channel: one signed Q1.15 sample per transfer, is_last closes the block.
// results channel: one transfer per closed block with rms (Q1.15, floor of the
// square root of the truncated mean square), sample_count and overflow.
// samples beyond MAX_SAMPLES in a block are dropped and flag overflow.
// throughput: one sample per cycle while the block queue has room; each block's
// closing work runs through the one-bit-per-cycle restoring divider and then
// the two-bit-per-cycle root.
// a two-entry queue of closed blocks sits between accumulation and the
// divide/root engine, so a new block keeps streaming while the last one closes;
// ready drops only when the queue and the closing sample in flight fill it.
// a stalled receiver holds the result register; the engine finishes the next
// block and waits for the register to free.
// reset clears the sum, count, overflow flag, the queue and all valid flags.
module signal_rms_meter
    import srm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    srm_in_if.sink     samples,
    srm_out_if.source  results
);

    queue_status_t q_status;
    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head;

    srm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    srm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    srm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .results  (results)
    );

endmodule

@@ rtl/srm_checker.sv @@
// port-level checks for the rms meter, bound to the top level
module srm_checker
    import srm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_last,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [RMS_W-1:0]       out_rms,
    input logic [COUNT_OUT_W-1:0] out_count,
    input logic                   out_ovf
);

    logic [3:0] open_blocks_reg;
    logic       in_close;
    logic       out_xfer;

    assign in_close = in_valid & in_ready & in_last;
    assign out_xfer = out_valid & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_blocks_reg <= '0;
        end
        else if (in_close && !out_xfer)
        begin
            open_blocks_reg <= open_blocks_reg + 4'd1;
        end
        else if (out_xfer && !in_close)
        begin
            open_blocks_reg <= open_blocks_reg - 4'd1;
        end
    end

    // result must belong to a block that was closed before
    a_result_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_blocks_reg != 4'd0)
        else $error("result without a closed block");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_rms <= RMS_W'(32768)) && (out_count != '0))
        else $error("result out of range");

    // overflow only once the block reached its limit
    a_overflow_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ovf) |-> out_count == COUNT_OUT_W'(MAX_SAMPLES))
        else $error("overflow with a short block");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_rms)
            && $stable(out_count) && $stable(out_ovf))
        else $error("result dropped or changed while stalled");

endmodule

bind signal_rms_meter srm_checker u_srm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_last   (samples.is_last),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_rms   (results.rms),
    .out_count (results.sample_count),
    .out_ovf   (results.overflow)
);
